// ===== rtl/chk_pkg.sv =====
// ----------------------------------------------------------------------------
// Chained hash key table package
// Shared types and constants for the chained hash key table.
// ----------------------------------------------------------------------------
package chk_pkg;

  localparam int unsigned NumBucketsDef = 64;
  localparam int unsigned PoolNodesDef  = 256;
  localparam int unsigned HandleBitsDef = 16;
  localparam int unsigned KeyBits       = 22;
  localparam int unsigned FuncBits      = 2;
  localparam int unsigned StatusBits    = 2;
  localparam int unsigned CfgBits       = 7;
  localparam logic [CfgBits-1:0] BucketCountRst = 7'd64;

  localparam logic [FuncBits-1:0] FuncInsert = 2'd0;
  localparam logic [FuncBits-1:0] FuncLookup = 2'd1;
  localparam logic [FuncBits-1:0] FuncRemove = 2'd2;

  localparam logic [StatusBits-1:0] StatOk       = 2'd0;
  localparam logic [StatusBits-1:0] StatNotFound = 2'd1;
  localparam logic [StatusBits-1:0] StatPoolFull = 2'd2;

  typedef struct packed {
    logic [FuncBits-1:0]      func;
    logic [KeyBits-1:0]       key_pid;
    logic [HandleBitsDef-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [StatusBits-1:0]    status;
    logic [HandleBitsDef-1:0] handle_out;
  } rsp_t;

endpackage

// ===== rtl/chk_front.sv =====
// ----------------------------------------------------------------------------
// Chained hash key table front end
// Accepts request beats, reduces the key to a bucket index with a
// shift-subtract remainder unit, and pushes classified work into a queue.
// ----------------------------------------------------------------------------
module chk_front import chk_pkg::*; #(
  parameter int unsigned NumBuckets = NumBucketsDef,
  parameter int unsigned BktBits    = (NumBuckets > 1) ? $clog2(NumBuckets) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  req_t               req_i,
  input  logic [CfgBits-1:0] bucket_count_i,
  output logic               wq_push_o,
  output req_t               wq_req_o,
  output logic [BktBits-1:0] wq_bkt_o,
  input  logic               wq_full_i
);

  localparam int unsigned CntBits = $clog2(KeyBits + 1);
  localparam int unsigned RemBits = CfgBits + 1;

  typedef enum logic [1:0] {StIdle, StDiv, StOut} state_e;

  state_e               state_q;
  req_t                 req_q;
  logic [KeyBits-1:0]   sh_q;
  logic [RemBits-1:0]   rem_q;
  logic [CntBits-1:0]   cnt_q;
  logic [CfgBits-1:0]   div_q;
  logic [CfgBits-1:0]   div_c;
  logic [RemBits-1:0]   trial;

  // Clamp bucket count to 1..NumBuckets.
  always_comb begin
    div_c = bucket_count_i;
    if (div_c == '0) div_c = CfgBits'(1);
    if (32'(div_c) > NumBuckets) div_c = CfgBits'(NumBuckets);
  end

  assign trial     = {rem_q[RemBits-2:0], sh_q[KeyBits-1]};
  assign full      = (state_q != StIdle);
  assign wq_push_o = (state_q == StOut);
  assign wq_req_o  = req_q;
  assign wq_bkt_o  = BktBits'(rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (push) begin
            req_q   <= req_i;
            sh_q    <= req_i.key_pid;
            rem_q   <= '0;
            div_q   <= div_c;
            cnt_q   <= CntBits'(KeyBits);
            state_q <= StDiv;
          end
        end
        StDiv: begin
          // One quotient bit per cycle.
          sh_q <= {sh_q[KeyBits-2:0], 1'b0};
          if (trial >= {1'b0, div_q}) rem_q <= trial - {1'b0, div_q};
          else rem_q <= trial;
          cnt_q <= cnt_q - CntBits'(1);
          if (cnt_q == CntBits'(1)) state_q <= StOut;
        end
        StOut: begin
          if (!wq_full_i) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/chk_queue.sv =====
// ----------------------------------------------------------------------------
// Chained hash key table work queue
// Two-entry queue between the front end and the chain walker.
// ----------------------------------------------------------------------------
module chk_queue import chk_pkg::*; #(
  parameter int unsigned BktBits = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  req_t               req_i,
  input  logic [BktBits-1:0] bkt_i,
  output logic               full_o,
  output logic               empty_o,
  input  logic               pop_i,
  output req_t               req_o,
  output logic [BktBits-1:0] bkt_o
);

  req_t               req_q [2];
  logic [BktBits-1:0] bkt_q [2];
  logic               wp_q, rp_q;
  logic [1:0]         cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign req_o   = req_q[rp_q];
  assign bkt_o   = bkt_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      req_q[wp_q] <= req_i;
      bkt_q[wp_q] <= bkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ===== rtl/chk_back.sv =====
// ----------------------------------------------------------------------------
// Chained hash key table back end
// Holds bucket heads and the node pool, walks chains with a read and check state
// per node, links and unlinks nodes, and keeps a one-entry result register.
// ----------------------------------------------------------------------------
module chk_back import chk_pkg::*; #(
  parameter int unsigned NumBuckets = NumBucketsDef,
  parameter int unsigned PoolNodes  = PoolNodesDef,
  parameter int unsigned BktBits    = (NumBuckets > 1) ? $clog2(NumBuckets) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wq_empty_i,
  output logic               wq_pop_o,
  input  req_t               wq_req_i,
  input  logic [BktBits-1:0] wq_bkt_i,
  output logic               empty,
  input  logic               pop,
  output rsp_t               rsp_o
);

  localparam int unsigned NodeBits = $clog2(PoolNodes + 1);
  localparam int unsigned IdxBits  = $clog2(PoolNodes);
  localparam logic [NodeBits-1:0] Nil = NodeBits'(PoolNodes);

  typedef enum logic [2:0] {
    StIdle, StHead, StAlloc, StRead, StCheck, StUnlink, StDone
  } state_e;

  // Heads have valid bits; an invalid head reads as empty.
  logic [NodeBits-1:0]      head_q [NumBuckets];
  logic [NumBuckets-1:0]    head_vld_q;
  logic [KeyBits-1:0]       key_mem [PoolNodes];
  logic [HandleBitsDef-1:0] hdl_mem [PoolNodes];
  logic [NodeBits-1:0]      lnk_mem [PoolNodes];

  state_e                   state_q;
  req_t                     req_q;
  logic [BktBits-1:0]       bkt_q;
  logic [NodeBits-1:0]      cur_q, prev_q, recyc_q, fresh_q;
  logic [KeyBits-1:0]       rd_key_q;
  logic [HandleBitsDef-1:0] rd_hdl_q;
  logic [NodeBits-1:0]      rd_lnk_q;
  logic [BktBits-1:0]       head_addr;
  logic [NodeBits-1:0]      head_rd_q;
  logic                     rsp_vld_q;
  rsp_t                     rsp_q;

  // The head read is addressed by the incoming beat while idle, so the head
  // is ready in the following cycle.
  assign head_addr = (state_q == StIdle) ? wq_bkt_i : bkt_q;
  assign wq_pop_o  = (state_q == StIdle) && !wq_empty_i && !rsp_vld_q;
  assign empty     = !rsp_vld_q;
  assign rsp_o     = rsp_q;

  // Read ports: registered data at the address in cur_q and at head_addr.
  always_ff @(posedge clk_i) begin
    rd_key_q  <= key_mem[cur_q[IdxBits-1:0]];
    rd_hdl_q  <= hdl_mem[cur_q[IdxBits-1:0]];
    rd_lnk_q  <= lnk_mem[cur_q[IdxBits-1:0]];
    head_rd_q <= head_vld_q[head_addr] ? head_q[head_addr] : Nil;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      head_vld_q <= '0;
      recyc_q    <= Nil;
      fresh_q    <= '0;
      rsp_vld_q  <= 1'b0;
    end else begin
      if (pop && rsp_vld_q) rsp_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (wq_pop_o) begin
            req_q  <= wq_req_i;
            bkt_q  <= wq_bkt_i;
            prev_q <= Nil;
            state_q <= StHead;
            if (wq_req_i.func == FuncInsert) begin
              if (recyc_q != Nil) cur_q <= recyc_q;
              else cur_q <= fresh_q;
            end
            rsp_q.status     <= StatNotFound;
            rsp_q.handle_out <= '0;
          end
        end
        StHead: begin
          priority if (req_q.func == FuncInsert) begin
            if (cur_q == Nil) begin
              rsp_q.status <= StatPoolFull;
              state_q      <= StDone;
            end else begin
              state_q <= StAlloc;
            end
          end else if (req_q.func == FuncLookup || req_q.func == FuncRemove) begin
            cur_q   <= head_rd_q;
            state_q <= (head_rd_q == Nil) ? StDone : StRead;
          end else begin
            state_q <= StDone;
          end
        end
        StAlloc: begin
          // Read port now holds the link of the node being allocated.
          if (recyc_q != Nil) recyc_q <= rd_lnk_q;
          else fresh_q <= fresh_q + NodeBits'(1);
          key_mem[cur_q[IdxBits-1:0]] <= req_q.key_pid;
          hdl_mem[cur_q[IdxBits-1:0]] <= req_q.handle_in;
          lnk_mem[cur_q[IdxBits-1:0]] <= head_rd_q;
          head_q[bkt_q]     <= cur_q;
          head_vld_q[bkt_q] <= 1'b1;
          rsp_q.status      <= StatOk;
          state_q           <= StDone;
        end
        StRead: state_q <= StCheck;
        StCheck: begin
          if (rd_key_q == req_q.key_pid) begin
            rsp_q.status     <= StatOk;
            rsp_q.handle_out <= rd_hdl_q;
            state_q <= (req_q.func == FuncRemove) ? StUnlink : StDone;
          end else begin
            prev_q <= cur_q;
            cur_q  <= rd_lnk_q;
            state_q <= (rd_lnk_q == Nil) ? StDone : StRead;
          end
        end
        StUnlink: begin
          if (prev_q != Nil) lnk_mem[prev_q[IdxBits-1:0]] <= rd_lnk_q;
          else begin
            head_q[bkt_q]     <= rd_lnk_q;
            head_vld_q[bkt_q] <= 1'b1;
          end
          lnk_mem[cur_q[IdxBits-1:0]] <= recyc_q;
          recyc_q <= cur_q;
          state_q <= StDone;
        end
        StDone: begin
          rsp_vld_q <= 1'b1;
          state_q   <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

// ===== rtl/chained_hash_key_table.sv =====
// ----------------------------------------------------------------------------
// Chained hash key table
// Hash table of process handles with separate chaining in a node pool.
// ----------------------------------------------------------------------------
// In the front end, the key modulo the bucket count is found one bit per cycle.
// The back end reads the bucket head, then for a lookup or remove visits each
// chain node with a read and a check state, adds an unlink state when a remove
// finds its key, and for an insert writes the node in an allocate state. The
// two run overlapped through a two-entry queue, so the front end sets the rate
// for short chains. Results are held in a one-beat output register, and the
// back end takes no new beat while a result waits there.
module chained_hash_key_table import chk_pkg::*; #(
  parameter int unsigned NumBuckets = NumBucketsDef,
  parameter int unsigned PoolNodes  = PoolNodesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  req_t               req_i,
  output logic               empty,
  input  logic               pop,
  output rsp_t               rsp_o,
  input  logic               cfg_we_i,
  input  logic [CfgBits-1:0] cfg_wdata_i
);

  localparam int unsigned BktBits = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;

  logic [CfgBits-1:0] bucket_count_q;
  logic               f_push, q_full, q_empty, q_pop;
  req_t               f_req, q_req;
  logic [BktBits-1:0] f_bkt, q_bkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bucket_count_q <= BucketCountRst;
    else if (cfg_we_i) bucket_count_q <= cfg_wdata_i;
  end

  chk_front #(.NumBuckets(NumBuckets), .BktBits(BktBits)) u_front (
    .clk_i, .rst_ni, .push, .full, .req_i,
    .bucket_count_i(bucket_count_q),
    .wq_push_o(f_push), .wq_req_o(f_req), .wq_bkt_o(f_bkt), .wq_full_i(q_full)
  );

  chk_queue #(.BktBits(BktBits)) u_queue (
    .clk_i, .rst_ni, .push_i(f_push), .req_i(f_req), .bkt_i(f_bkt),
    .full_o(q_full), .empty_o(q_empty), .pop_i(q_pop),
    .req_o(q_req), .bkt_o(q_bkt)
  );

  chk_back #(.NumBuckets(NumBuckets), .PoolNodes(PoolNodes), .BktBits(BktBits))
  u_back (
    .clk_i, .rst_ni, .wq_empty_i(q_empty), .wq_pop_o(q_pop),
    .wq_req_i(q_req), .wq_bkt_i(q_bkt), .empty, .pop, .rsp_o
  );

endmodule
